/* hw/rtl/xtea_block_cipher_assert.svh */
// ----------------------------------------------------------------------------
// XTEA assertion macros
// Concurrent assertion wrappers used by the cipher RTL; compiled out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define XTEA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define XTEA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XTEA_ASSERT(lbl, prop, msg)
`define XTEA_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* hw/rtl/xtea_pkg.sv */
// ----------------------------------------------------------------------------
// XTEA package
// Word types, key type, register indexes and cipher constants.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int ROUNDS = 32;
  localparam int NCELLS = 2 * ROUNDS;

  localparam logic [31:0] DELTA = 32'h9E3779B9;
  localparam logic [31:0] DEC_SUM = 32'(64'(DELTA) * 64'(ROUNDS));

  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = CFG_IDX_W'(3);

  typedef enum logic {
    CMD_ENC = 1'b0,
    CMD_DEC = 1'b1
  } cmd_t;

  typedef logic [3:0][31:0] key_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] block_left;
    logic [31:0] block_right;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_left;
    logic [31:0] result_right;
  } out_word_t;

  // one half-round in flight
  typedef struct packed {
    cmd_t        cmd;
    logic        ph;
    logic [31:0] s;
    logic [31:0] a;
    logic [31:0] b;
  } stage_t;

endpackage

/* hw/rtl/xtea_key_regs.sv */
// ----------------------------------------------------------------------------
// XTEA key registers
// Four 32-bit key words written through the configuration port.
// ----------------------------------------------------------------------------
module xtea_key_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]                    cfg_wdata,
  output xtea_pkg::key_t                 key
);
  import xtea_pkg::*;

  key_t key_r;
  key_t key_nxt;

  always_comb begin
    key_nxt = key_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_KEY0: key_nxt[0] = cfg_wdata;
        REG_KEY1: key_nxt[1] = cfg_wdata;
        REG_KEY2: key_nxt[2] = cfg_wdata;
        REG_KEY3: key_nxt[3] = cfg_wdata;
        default:  key_nxt = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  assign key = key_r;

endmodule

/* hw/rtl/xtea_cell.sv */
// ----------------------------------------------------------------------------
// XTEA cell
// One registered half-round; alternates halves via the phase bit and
// passes its word downstream with a valid/ready handshake.
// ----------------------------------------------------------------------------
`include "xtea_block_cipher_assert.svh"

module xtea_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  xtea_pkg::key_t   key,
  input  logic             up_valid,
  output logic             up_ready,
  input  xtea_pkg::stage_t up_word,
  output logic             dn_valid,
  input  logic             dn_ready,
  output xtea_pkg::stage_t dn_word
);
  import xtea_pkg::*;

  logic        v_r;
  logic        v_nxt;
  stage_t      word_r;
  stage_t      word_nxt;

  logic        modb;
  logic [1:0]  sel;
  logic [31:0] src;
  logic [31:0] dst;
  logic [31:0] mix;
  logic [31:0] f;
  logic [31:0] res;
  logic        load;

  assign up_ready = !v_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    // encrypt: even half updates a, odd updates b; decrypt the reverse
    modb = (up_word.cmd == CMD_DEC) ^ up_word.ph;
    sel  = modb ? up_word.s[12:11] : up_word.s[1:0];
    src  = modb ? up_word.a : up_word.b;
    dst  = modb ? up_word.b : up_word.a;
    mix  = ((src << 4) ^ (src >> 5)) + src;
    f    = mix ^ (up_word.s + key[sel]);
    res  = (up_word.cmd == CMD_DEC) ? dst - f : dst + f;

    word_nxt     = up_word;
    word_nxt.ph  = !up_word.ph;
    word_nxt.a   = modb ? up_word.a : res;
    word_nxt.b   = modb ? res : up_word.b;
    if (!up_word.ph) begin
      word_nxt.s = (up_word.cmd == CMD_DEC) ? up_word.s - DELTA : up_word.s + DELTA;
    end

    v_nxt = load ? 1'b1 : (dn_ready ? 1'b0 : v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_word  = word_r;

  `XTEA_ASSERT(a_stall_hold, dn_valid && !dn_ready |=> dn_valid && $stable(dn_word), "stalled word changed")
  `XTEA_ASSERT(a_odd_sum, load && up_word.ph |=> dn_word.s == $past(up_word.s), "sum moved on odd half")
  `XTEA_ASSERT(a_empty_ready, !dn_valid |-> up_ready, "empty cell not ready")
  `XTEA_ASSERT_RST(a_rst_clear, !rst_n |=> !dn_valid, "valid survived reset")

endmodule

/* hw/rtl/xtea_block_cipher.sv */
// ----------------------------------------------------------------------------
// XTEA block cipher
// ECB encrypt/decrypt of 64-bit blocks with a 128-bit configured key.
// ----------------------------------------------------------------------------
// Each block passes through a chain of 2*ROUNDS cells (64 for 32 rounds), one
// half-round per registered cell, and a new block is taken every cycle while
// the result channel is not stalled. Every cell has its own valid/ready stage,
// so a stalled output only holds the cells that are full; empty cells behind
// it keep accepting. The user must write key words through the cfg port only
// while no blocks are in flight; the block itself does not enforce this. A
// write to an index above 3 is ignored.
module xtea_block_cipher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  xtea_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output xtea_pkg::out_word_t            out_word
);
  import xtea_pkg::*;

  key_t   key;
  logic   v   [NCELLS+1];
  logic   rdy [NCELLS+1];
  stage_t w   [NCELLS+1];

  xtea_key_regs u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .key       (key)
  );

  always_comb begin
    w[0].cmd = in_word.cmd;
    w[0].ph  = 1'b0;
    w[0].s   = (in_word.cmd == CMD_DEC) ? DEC_SUM : '0;
    w[0].a   = in_word.block_left;
    w[0].b   = in_word.block_right;
  end

  assign v[0]        = in_valid;
  assign in_ready    = rdy[0];
  assign rdy[NCELLS] = out_ready;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    xtea_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .key      (key),
      .up_valid (v[i]),
      .up_ready (rdy[i]),
      .up_word  (w[i]),
      .dn_valid (v[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_word  (w[i+1])
    );
  end

  assign out_valid             = v[NCELLS];
  assign out_word.result_left  = w[NCELLS].a;
  assign out_word.result_right = w[NCELLS].b;

endmodule

/* tb/sv/xtea_block_cipher_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block cipher checker
// Follows the key writes on the cfg port and computes the expected cipher
// result for every word taken on the input channel. Each word leaving the
// result channel is compared field by field with the oldest expected result.
// The top reads the failure count and the progress counters.
// ----------------------------------------------------------------------------
module xtea_block_cipher_checker
  import xtea_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]          cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_word_t             in_word,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_word_t            out_word,
  output int unsigned          fail_count,
  output int unsigned          results_seen,
  output int unsigned          backlog
);

  localparam logic [31:0] GOLDEN    = 32'h9E3779B9;
  localparam logic [31:0] DEC_START = GOLDEN * 32'(ROUNDS);
  localparam int unsigned REPORT_MAX = 10;

  key_t      cipher_key;
  out_word_t pending_blocks[$];
  out_word_t want;

  function automatic logic [31:0] round_mix(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  function automatic out_word_t xtea_transform(input in_word_t w, input key_t k);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] s;
    out_word_t   r;
    a = w.block_left;
    b = w.block_right;
    if (w.cmd == CMD_ENC) begin
      s = '0;
      for (int n = 0; n < ROUNDS; n++) begin
        a += round_mix(b) ^ (s + k[s[1:0]]);
        s += GOLDEN;
        b += round_mix(a) ^ (s + k[s[12:11]]);
      end
    end else begin
      s = DEC_START;
      for (int n = 0; n < ROUNDS; n++) begin
        b -= round_mix(a) ^ (s + k[s[12:11]]);
        s -= GOLDEN;
        a -= round_mix(b) ^ (s + k[s[1:0]]);
      end
    end
    r.result_left  = a;
    r.result_right = b;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cipher_key = '0;
      pending_blocks.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (in_valid && in_ready)
        pending_blocks.push_back(xtea_transform(in_word, cipher_key));
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_blocks.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("[%0t] unexpected result word %08h_%08h", $time,
                     out_word.result_left, out_word.result_right);
        end else begin
          want = pending_blocks.pop_front();
          if (out_word.result_left !== want.result_left ||
              out_word.result_right !== want.result_right) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("[%0t] result mismatch: expected %08h_%08h, got %08h_%08h",
                       $time, want.result_left, want.result_right,
                       out_word.result_left, out_word.result_right);
          end
        end
      end
      // indexes above the last key word are dropped
      if (cfg_we && cfg_idx <= REG_KEY3)
        cipher_key[cfg_idx[1:0]] = cfg_wdata;
    end
    backlog = pending_blocks.size();
  end

endmodule

/* tb/sv/xtea_block_cipher_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block cipher testbench
// Streams directed and random encrypt/decrypt words through the cipher under
// several keys, with random gaps on both channels and one long result stall
// that backs the pipeline up into the input. The checker predicts and
// compares; this module drives stimulus and prints the verdict.
// ----------------------------------------------------------------------------
module xtea_block_cipher_tb;
  import xtea_pkg::*;

  localparam int unsigned STALL_LIMIT    = 3000;
  localparam int unsigned SQUEEZE_AT     = 300;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES   = 2 * NCELLS + 16;
  localparam int unsigned KEY_PHASES     = 6;
  localparam int unsigned PHASE_WORDS    = 215;
  localparam logic [CFG_IDX_W-1:0] TOP_IDX = '1;
  localparam logic [CFG_IDX_W-1:0] KEY_REGS[4] = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [31:0]          cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_word;

  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned backlog;
  int unsigned words_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          squeezed    = 1'b0;
  bit          steady      = 1'b0;

  always #5 clk = ~clk;

  xtea_block_cipher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  xtea_block_cipher_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word     (out_word),
    .fail_count   (fail_count),
    .results_seen (results_seen),
    .backlog      (backlog)
  );

  function automatic int unsigned idle_len(input bit quiet);
    int unsigned roll;
    if (quiet)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    if (roll < 85)
      return $urandom_range(1, 3);
    if (roll < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] pick_half();
    case ($urandom_range(0, 9))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return 32'h1 << $urandom_range(0, 31);
      end
      default: begin
        return $urandom();
      end
    endcase
  endfunction

  function automatic in_word_t make_word(input cmd_t c, input logic [31:0] l,
                                         input logic [31:0] r);
    in_word_t w;
    w.cmd         = c;
    w.block_left  = l;
    w.block_right = r;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    gap = idle_len(steady);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    wait (results_seen >= words_sent);
    @(posedge clk);
  endtask

  task automatic load_key(input key_t k);
    // stray writes around the key words must not touch the key
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_IDX_W'($urandom_range(int'(TOP_IDX), int'(REG_KEY3) + 1));
    cfg_wdata <= $urandom();
    @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_idx   <= KEY_REGS[i];
      cfg_wdata <= k[i];
      @(posedge clk);
    end
    cfg_idx   <= TOP_IDX;
    cfg_wdata <= $urandom();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("xtea_block_cipher regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned run;
    int unsigned gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!squeezed && words_sent >= SQUEEZE_AT) begin
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeezed = 1'b1;
      end
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      gap = idle_len(1'b0);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    key_t k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key of all zeros
    send_word(make_word(CMD_ENC, 32'h0000_0000, 32'h0000_0000));
    send_word(make_word(CMD_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(CMD_DEC, 32'h0000_0000, 32'h0000_0000));
    send_word(make_word(CMD_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(CMD_ENC, 32'h8000_0000, 32'h0000_0001));
    send_word(make_word(CMD_DEC, 32'h0000_0001, 32'h8000_0000));
    settle();

    // well-known key with a known plaintext/ciphertext pair
    k = {32'h0C0D_0E0F, 32'h0809_0A0B, 32'h0405_0607, 32'h0001_0203};
    load_key(k);
    send_word(make_word(CMD_ENC, 32'h4142_4344, 32'h4546_4748));
    send_word(make_word(CMD_DEC, 32'h497D_F3D0, 32'h7261_2CB5));
    send_word(make_word(CMD_ENC, 32'hAAAA_AAAA, 32'h5555_5555));
    send_word(make_word(CMD_DEC, 32'h5555_5555, 32'hAAAA_AAAA));
    send_word(make_word(CMD_ENC, 32'h0000_0000, 32'hFFFF_FFFF));
    send_word(make_word(CMD_DEC, 32'hFFFF_FFFF, 32'h0000_0000));

    for (int unsigned phase = 0; phase < KEY_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          k = '1;
        end
        2: begin
          k = {32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
        end
        4: begin
          k = '0;
        end
        default: begin
          k = {$urandom(), $urandom(), $urandom(), $urandom()};
        end
      endcase
      load_key(k);
      for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
        if (n % 64 == 0)
          steady = ($urandom_range(0, 3) == 0);
        send_word(make_word(cmd_t'($urandom_range(0, 1)), pick_half(), pick_half()));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && backlog == 0)
      $display("xtea_block_cipher regression: pass");
    else
      $display("xtea_block_cipher regression: fail");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/xtea_pkg.sv
hw/rtl/xtea_key_regs.sv
hw/rtl/xtea_cell.sv
hw/rtl/xtea_block_cipher.sv
tb/sv/xtea_block_cipher_checker.sv
tb/sv/xtea_block_cipher_tb.sv
